// ----- rtl/atpr_pkg.sv -----
// atpr_pkg: types, widths, angle table and step functions for the tilt pipeline
// depends on nothing; used by accel_tilt_pitch_roll
`default_nettype none

package atpr_pkg;

    // pipeline depth of each vectoring cordic
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;

    // sample and fixed-point widths
    localparam int IN_W      = 16;
    localparam int FRAC_BITS = 16;
    localparam int CW        = 35;
    localparam int TURN_BITS = 32;
    localparam int ANG_W     = TURN_BITS + 2;
    localparam int MAG_W     = ANG_W - 1;

    // sum of squares and square root
    localparam int SQ_W      = 2 * IN_W - 1;
    localparam int SS_W      = SQ_W + 1;
    localparam int ROOT_W    = (SS_W + TURN_BITS) / 2;
    localparam int SQRT_BITS = ROOT_W;
    localparam int REM_W     = ROOT_W + 2;

    // angle conversion to centidegrees
    localparam int CENTIDEG_PER_TURN = 36000;
    localparam int CD_W              = 16;
    localparam int PROD_W            = MAG_W + CD_W;
    localparam int Q_W               = PROD_W + 1 - TURN_BITS;

    // result widths and limits
    localparam int PITCH_W   = 15;
    localparam int ROLL_W    = 16;
    localparam int PITCH_LIM = 9000;
    localparam int ROLL_LIM  = 18000;

    localparam logic signed [ANG_W-1:0] ANG_QUARTER = ANG_W'(2 ** (TURN_BITS - 2));

    // count of stage registers between an accepted word and its result strobe
    localparam int LATENCY = SQRT_BITS + CORDIC_STAGES + 6;

    typedef struct packed {
        logic signed [IN_W-1:0] accel_x;
        logic signed [IN_W-1:0] accel_y;
        logic signed [IN_W-1:0] accel_z;
    } t_sample;

    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch_centideg;
        logic signed [ROLL_W-1:0]  roll_centideg;
    } t_tilt;

    typedef struct packed {
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
        logic signed [ANG_W-1:0] a;
    } t_vec;

    // special cases decided at the front, applied at the end
    typedef struct packed {
        logic roll_on_axis;
        logic roll_back;
        logic pitch_zero;
        logic pitch_vertical;
        logic x_pos;
    } t_flags;

    typedef struct packed {
        logic [SQ_W-1:0]      sq_y;
        logic [SQ_W-1:0]      sq_z;
        logic signed [CW-1:0] pitch_y;
        t_vec                 roll;
        t_flags               flags;
    } t_front;

    typedef struct packed {
        logic [SS_W-1:0]      ss;
        logic [ROOT_W-1:0]    root;
        logic [REM_W-1:0]     rem;
        logic signed [CW-1:0] pitch_y;
        t_vec                 roll;
        t_flags               flags;
    } t_sq;

    typedef struct packed {
        t_vec   pitch;
        t_vec   roll;
        t_flags flags;
    } t_co;

    typedef struct packed {
        logic [MAG_W-1:0] pitch_mag;
        logic             pitch_neg;
        logic [MAG_W-1:0] roll_mag;
        logic             roll_neg;
        t_flags           flags;
    } t_cv1;

    typedef struct packed {
        logic [PROD_W-1:0] pitch_prod;
        logic              pitch_neg;
        logic [PROD_W-1:0] roll_prod;
        logic              roll_neg;
        t_flags            flags;
    } t_cv2;

    // atan(2^-i) in binary turns, 2^32 per turn
    function automatic logic signed [ANG_W-1:0] atan_turn(input int unsigned idx);
        logic signed [ANG_W-1:0] v;
        unique case (idx)
            0:       v = ANG_W'(536870912);
            1:       v = ANG_W'(316933406);
            2:       v = ANG_W'(167458907);
            3:       v = ANG_W'(85004756);
            4:       v = ANG_W'(42667331);
            5:       v = ANG_W'(21354465);
            6:       v = ANG_W'(10679838);
            7:       v = ANG_W'(5340245);
            8:       v = ANG_W'(2670163);
            9:       v = ANG_W'(1335087);
            10:      v = ANG_W'(667544);
            11:      v = ANG_W'(333772);
            12:      v = ANG_W'(166886);
            13:      v = ANG_W'(83443);
            14:      v = ANG_W'(41722);
            15:      v = ANG_W'(20861);
            16:      v = ANG_W'(10430);
            17:      v = ANG_W'(5215);
            18:      v = ANG_W'(2608);
            19:      v = ANG_W'(1304);
            20:      v = ANG_W'(652);
            21:      v = ANG_W'(326);
            22:      v = ANG_W'(163);
            23:      v = ANG_W'(81);
            default: v = '0;
        endcase
        return v;
    endfunction

    // sign-extended sample with 16 fraction bits
    function automatic logic signed [CW-1:0] fix_of(input logic signed [IN_W:0] v);
        logic signed [CW-1:0] r;
        r = CW'(v);
        return r <<< FRAC_BITS;
    endfunction

    // one vectoring micro-rotation; stages past the table pass through
    function automatic t_vec cordic_step(input t_vec v, input int unsigned idx);
        logic signed [CW-1:0]    vx;
        logic signed [CW-1:0]    vy;
        logic signed [CW-1:0]    xs;
        logic signed [CW-1:0]    ys;
        logic signed [ANG_W-1:0] va;
        logic signed [ANG_W-1:0] ang;
        t_vec                    r;
        vx  = v.x;
        vy  = v.y;
        va  = v.a;
        xs  = vx >>> idx;
        ys  = vy >>> idx;
        ang = atan_turn(idx);
        r   = v;
        if (idx < TABLE_LEN) begin
            if (!vy[CW-1] && (vy != '0)) begin
                r.x = vx + ys;
                r.y = vy - xs;
                r.a = va + ang;
            end else begin
                r.x = vx - ys;
                r.y = vy + xs;
                r.a = va - ang;
            end
        end
        return r;
    endfunction

    // scaled product to rounded, clamped, signed centidegrees
    function automatic logic signed [ROLL_W-1:0] centideg(
        input logic [PROD_W-1:0] prod,
        input logic              neg,
        input int                lim
    );
        logic [PROD_W:0]          sum;
        logic [Q_W-1:0]           q;
        logic signed [ROLL_W-1:0] m;
        sum = {1'b0, prod} + ((PROD_W + 1)'(1) << (TURN_BITS - 1));
        q   = sum[PROD_W:TURN_BITS];
        if (q > Q_W'(lim)) begin
            q = Q_W'(lim);
        end
        m = ROLL_W'(q);
        return neg ? -m : m;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/accel_tilt_pitch_roll.sv -----
// accel_tilt_pitch_roll: pitch and roll from one accelerometer word
// depends on atpr_pkg (types, widths, angle table, step functions)
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+----------------------------------
//  sample   | i_start, i_sample, o_busy      | taken when i_start and !o_busy
//  result   | o_valid, o_result              | one-cycle strobe, cannot stall
//
// one word can enter every cycle outside reset; its result strobe comes out once
// the word has passed through these registered stages, in order:
// 1 squaring stage, 1 sum stage, 32 square-root stages (one root bit each),
// 1 cordic entry stage, 16 rotation stages, 3 conversion stages
// synchronous active-low reset clears all valid bits; o_busy is high only
// while reset is held, so words in flight are dropped and none are taken then
`default_nettype none

module accel_tilt_pitch_roll (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire atpr_pkg::t_sample i_sample,
    output logic                   o_busy,
    output logic                   o_valid,
    output atpr_pkg::t_tilt        o_result
);

    localparam int NSQ = atpr_pkg::SQRT_BITS;
    localparam int NCO = atpr_pkg::CORDIC_STAGES;

    logic accept;

    logic              r_s0_vld;
    atpr_pkg::t_front  r_s0;
    atpr_pkg::t_front  n_s0;

    logic [NSQ:0]      r_sq_vld;
    atpr_pkg::t_sq     r_sq [NSQ+1];
    atpr_pkg::t_sq     n_sq [NSQ+1];

    logic [NCO:0]      r_co_vld;
    atpr_pkg::t_co     r_co [NCO+1];
    atpr_pkg::t_co     n_co [NCO+1];

    logic              r_cv1_vld;
    atpr_pkg::t_cv1    r_cv1;
    atpr_pkg::t_cv1    n_cv1;
    logic              r_cv2_vld;
    atpr_pkg::t_cv2    r_cv2;
    atpr_pkg::t_cv2    n_cv2;
    logic              r_out_vld;
    atpr_pkg::t_tilt   r_out;
    atpr_pkg::t_tilt   n_out;

    // pipeline takes a word every cycle outside reset
    assign o_busy = !i_rst_n;
    assign accept = i_start && !o_busy;

    // front: squares, pitch y component, roll pre-rotation into the right half plane
    always_comb begin
        logic signed [atpr_pkg::IN_W:0]     xe;
        logic signed [atpr_pkg::IN_W:0]     ye;
        logic signed [atpr_pkg::IN_W:0]     ze;
        logic signed [2*atpr_pkg::IN_W-1:0] yy;
        logic signed [2*atpr_pkg::IN_W-1:0] zz;
        xe = {i_sample.accel_x[atpr_pkg::IN_W-1], i_sample.accel_x};
        ye = {i_sample.accel_y[atpr_pkg::IN_W-1], i_sample.accel_y};
        ze = {i_sample.accel_z[atpr_pkg::IN_W-1], i_sample.accel_z};
        yy = i_sample.accel_y * i_sample.accel_y;
        zz = i_sample.accel_z * i_sample.accel_z;
        n_s0.sq_y    = yy[atpr_pkg::SQ_W-1:0];
        n_s0.sq_z    = zz[atpr_pkg::SQ_W-1:0];
        n_s0.pitch_y = atpr_pkg::fix_of(-xe);
        if (ze[atpr_pkg::IN_W]) begin
            if (!ye[atpr_pkg::IN_W] && (ye != '0)) begin
                n_s0.roll.x = atpr_pkg::fix_of(ye);
                n_s0.roll.y = atpr_pkg::fix_of(-ze);
                n_s0.roll.a = atpr_pkg::ANG_QUARTER;
            end else begin
                n_s0.roll.x = atpr_pkg::fix_of(-ye);
                n_s0.roll.y = atpr_pkg::fix_of(ze);
                n_s0.roll.a = -atpr_pkg::ANG_QUARTER;
            end
        end else begin
            n_s0.roll.x = atpr_pkg::fix_of(ze);
            n_s0.roll.y = atpr_pkg::fix_of(ye);
            n_s0.roll.a = '0;
        end
        n_s0.flags.roll_on_axis   = (ye == '0);
        n_s0.flags.roll_back      = ze[atpr_pkg::IN_W];
        n_s0.flags.pitch_zero     = (xe == '0);
        n_s0.flags.pitch_vertical = (ye == '0) && (ze == '0);
        n_s0.flags.x_pos          = !xe[atpr_pkg::IN_W] && (xe != '0);
    end

    // square-root entry: sum of squares, empty root and remainder
    always_comb begin
        n_sq[0].ss      = atpr_pkg::SS_W'(r_s0.sq_y) + atpr_pkg::SS_W'(r_s0.sq_z);
        n_sq[0].root    = '0;
        n_sq[0].rem     = '0;
        n_sq[0].pitch_y = r_s0.pitch_y;
        n_sq[0].roll    = r_s0.roll;
        n_sq[0].flags   = r_s0.flags;
    end

    // restoring square root of ss * 2^32, one root bit per stage
    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        logic [1:0]                  pair;
        logic [atpr_pkg::REM_W+1:0] acc;
        logic [atpr_pkg::REM_W+1:0] trial;

        if (k < atpr_pkg::SS_W / 2) begin : g_digit
            assign pair = r_sq[k].ss[atpr_pkg::SS_W-1-2*k -: 2];
        end else begin : g_pad
            assign pair = 2'b00;
        end

        always_comb begin
            acc     = {r_sq[k].rem, pair};
            trial   = (atpr_pkg::REM_W + 2)'({r_sq[k].root, 2'b01});
            n_sq[k+1] = r_sq[k];
            if (acc >= trial) begin
                n_sq[k+1].rem  = atpr_pkg::REM_W'(acc - trial);
                n_sq[k+1].root = {r_sq[k].root[atpr_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_sq[k+1].rem  = acc[atpr_pkg::REM_W-1:0];
                n_sq[k+1].root = {r_sq[k].root[atpr_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    // cordic entry: pitch vector is (radius, -x)
    always_comb begin
        n_co[0].pitch.x = atpr_pkg::CW'(r_sq[NSQ].root);
        n_co[0].pitch.y = r_sq[NSQ].pitch_y;
        n_co[0].pitch.a = '0;
        n_co[0].roll    = r_sq[NSQ].roll;
        n_co[0].flags   = r_sq[NSQ].flags;
    end

    // pitch and roll micro-rotations side by side
    for (genvar i = 0; i < NCO; i++) begin : g_cordic
        always_comb begin
            n_co[i+1].pitch = atpr_pkg::cordic_step(r_co[i].pitch, i);
            n_co[i+1].roll  = atpr_pkg::cordic_step(r_co[i].roll, i);
            n_co[i+1].flags = r_co[i].flags;
        end
    end

    // angle magnitudes and signs
    always_comb begin
        logic signed [atpr_pkg::ANG_W-1:0] pa;
        logic signed [atpr_pkg::ANG_W-1:0] ra;
        pa = r_co[NCO].pitch.a;
        ra = r_co[NCO].roll.a;
        n_cv1.pitch_neg = pa[atpr_pkg::ANG_W-1];
        n_cv1.pitch_mag = pa[atpr_pkg::ANG_W-1] ? atpr_pkg::MAG_W'(-pa)
                                                 : atpr_pkg::MAG_W'(pa);
        n_cv1.roll_neg  = ra[atpr_pkg::ANG_W-1];
        n_cv1.roll_mag  = ra[atpr_pkg::ANG_W-1] ? atpr_pkg::MAG_W'(-ra)
                                                 : atpr_pkg::MAG_W'(ra);
        n_cv1.flags     = r_co[NCO].flags;
    end

    // scale turns to centidegrees
    always_comb begin
        n_cv2.pitch_prod = atpr_pkg::PROD_W'(r_cv1.pitch_mag)
                         * atpr_pkg::PROD_W'(atpr_pkg::CENTIDEG_PER_TURN);
        n_cv2.roll_prod  = atpr_pkg::PROD_W'(r_cv1.roll_mag)
                         * atpr_pkg::PROD_W'(atpr_pkg::CENTIDEG_PER_TURN);
        n_cv2.pitch_neg  = r_cv1.pitch_neg;
        n_cv2.roll_neg   = r_cv1.roll_neg;
        n_cv2.flags      = r_cv1.flags;
    end

    // round, clamp, and apply the axis special cases
    always_comb begin
        logic signed [atpr_pkg::ROLL_W-1:0] pc;
        logic signed [atpr_pkg::ROLL_W-1:0] rc;
        pc = atpr_pkg::centideg(r_cv2.pitch_prod, r_cv2.pitch_neg, atpr_pkg::PITCH_LIM);
        rc = atpr_pkg::centideg(r_cv2.roll_prod, r_cv2.roll_neg, atpr_pkg::ROLL_LIM);
        priority if (r_cv2.flags.pitch_zero) begin
            n_out.pitch_centideg = '0;
        end else if (r_cv2.flags.pitch_vertical) begin
            n_out.pitch_centideg = r_cv2.flags.x_pos
                ? -atpr_pkg::PITCH_W'(atpr_pkg::PITCH_LIM)
                :  atpr_pkg::PITCH_W'(atpr_pkg::PITCH_LIM);
        end else begin
            n_out.pitch_centideg = atpr_pkg::PITCH_W'(pc);
        end
        if (r_cv2.flags.roll_on_axis) begin
            n_out.roll_centideg = r_cv2.flags.roll_back
                ? atpr_pkg::ROLL_W'(atpr_pkg::ROLL_LIM) : '0;
        end else begin
            n_out.roll_centideg = rc;
        end
    end

    // valid bits travel with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld  <= 1'b0;
            r_sq_vld  <= '0;
            r_co_vld  <= '0;
            r_cv1_vld <= 1'b0;
            r_cv2_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s0_vld  <= accept;
            r_sq_vld  <= {r_sq_vld[NSQ-1:0], r_s0_vld};
            r_co_vld  <= {r_co_vld[NCO-1:0], r_sq_vld[NSQ]};
            r_cv1_vld <= r_co_vld[NCO];
            r_cv2_vld <= r_cv1_vld;
            r_out_vld <= r_cv2_vld;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_s0 <= n_s0;
        for (int k = 0; k <= NSQ; k++) begin
            r_sq[k] <= n_sq[k];
        end
        for (int i = 0; i <= NCO; i++) begin
            r_co[i] <= n_co[i];
        end
        r_cv1 <= n_cv1;
        r_cv2 <= n_cv2;
        r_out <= n_out;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    // every result strobe traces back to an accepted word that passed through every stage register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, atpr_pkg::LATENCY))
        else $error("result strobe without a matching accepted word");

    // pitch stays within a quarter turn
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.pitch_centideg <= atpr_pkg::PITCH_W'(atpr_pkg::PITCH_LIM))
                 && (o_result.pitch_centideg >= -atpr_pkg::PITCH_W'(atpr_pkg::PITCH_LIM)))
        else $error("pitch out of range");

    // roll stays within a half turn
    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.roll_centideg <= atpr_pkg::ROLL_W'(atpr_pkg::ROLL_LIM))
                 && (o_result.roll_centideg >= -atpr_pkg::ROLL_W'(atpr_pkg::ROLL_LIM)))
        else $error("roll out of range");

    // a nonzero y or z must leave a nonzero radius out of the square root
    a_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_co_vld[0] && !r_co[0].flags.pitch_vertical) |-> (r_co[0].pitch.x != '0))
        else $error("square root lost a nonzero radius");

endmodule

`default_nettype wire

// ----- bench/tb_accel_tilt_pitch_roll.sv -----
`timescale 1ns / 100ps
// tb_accel_tilt_pitch_roll: self-checking bench for the tilt pipeline, directed then
// random sample words, each tilt word checked against a built-in cordic angle predictor
// depends on atpr_pkg and accel_tilt_pitch_roll
module tb_accel_tilt_pitch_roll;

    localparam int     N_RANDOM        = 1450;
    localparam int     ANGLE_TABLE_LEN = 24;
    localparam longint QUARTER_TURN    = 64'sd1073741824;
    localparam int     DRAIN_LIMIT     = 4 * atpr_pkg::LATENCY + 100;

    // one pending sample word and the idle cycles that follow its acceptance
    typedef struct packed {
        atpr_pkg::t_sample sample;
        logic [7:0]        idle_after;
    } t_word_slot;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              i_start  = 1'b0;
    atpr_pkg::t_sample i_sample = '0;
    logic              o_busy;
    logic              o_valid;
    atpr_pkg::t_tilt   o_result;

    t_word_slot      sample_q[$];
    atpr_pkg::t_tilt tilt_expected_q[$];
    t_word_slot      next_slot;
    atpr_pkg::t_tilt want;
    int              idle_left     = 0;
    int              n_words_total = 0;
    int              n_words_taken = 0;
    int              n_errors      = 0;

    accel_tilt_pitch_roll u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_sample (i_sample),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // atan(2^-i) in binary turns, 2^32 per turn
    function automatic longint stage_angle(input int idx);
        case (idx)
            0:       return 536870912;
            1:       return 316933406;
            2:       return 167458907;
            3:       return 85004756;
            4:       return 42667331;
            5:       return 21354465;
            6:       return 10679838;
            7:       return 5340245;
            8:       return 2670163;
            9:       return 1335087;
            10:      return 667544;
            11:      return 333772;
            12:      return 166886;
            13:      return 83443;
            14:      return 41722;
            15:      return 20861;
            16:      return 10430;
            17:      return 5215;
            18:      return 2608;
            19:      return 1304;
            20:      return 652;
            21:      return 326;
            22:      return 163;
            23:      return 81;
            default: return 0;
        endcase
    endfunction

    // vectoring rotations, angle accumulated from a0
    function automatic longint vector_angle(input longint x0, input longint y0,
                                            input longint a0);
        longint x;
        longint y;
        longint a;
        longint xs;
        longint ys;
        x = x0;
        y = y0;
        a = a0;
        for (int i = 0; i < atpr_pkg::CORDIC_STAGES && i < ANGLE_TABLE_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                a = a + stage_angle(i);
            end else begin
                x = x - ys;
                y = y + xs;
                a = a - stage_angle(i);
            end
        end
        return a;
    endfunction

    // floor of the square root, one result bit per pass
    function automatic longint unsigned root_floor(input longint unsigned n0);
        longint unsigned n;
        longint unsigned res;
        longint unsigned b;
        n   = n0;
        res = 0;
        b   = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // binary turns to centidegrees, half away from zero, then clamped
    function automatic longint centideg_of(input longint a, input longint lim);
        longint unsigned mag;
        longint unsigned q;
        longint          v;
        mag = (a < 0) ? -a : a;
        q   = (mag * 64'd36000 + (64'd1 << 31)) >> 32;
        v   = $signed(q);
        if (a < 0) v = -v;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v;
    endfunction

    // expected tilt word for one sample word
    function automatic atpr_pkg::t_tilt tilt_of(input atpr_pkg::t_sample s);
        longint          x;
        longint          y;
        longint          z;
        longint          vx;
        longint          vy;
        longint          a0;
        longint          r;
        longint          pitch;
        longint          roll;
        longint unsigned ss;
        atpr_pkg::t_tilt res;
        x = longint'($signed(s.accel_x));
        y = longint'($signed(s.accel_y));
        z = longint'($signed(s.accel_z));

        // roll: on the z axis directly, left half plane pre-rotated by a quarter turn
        if (y == 0) begin
            roll = (z < 0) ? longint'(atpr_pkg::ROLL_LIM) : 64'sd0;
        end else begin
            vx = z * 65536;
            vy = y * 65536;
            a0 = 0;
            if (vx < 0) begin
                if (vy > 0) begin
                    vx = vy;
                    vy = -z * 65536;
                    a0 = QUARTER_TURN;
                end else begin
                    vx = -vy;
                    vy = z * 65536;
                    a0 = -QUARTER_TURN;
                end
            end
            roll = centideg_of(vector_angle(vx, vy, a0), longint'(atpr_pkg::ROLL_LIM));
        end

        // pitch: zero x, straight up or down, or cordic on the yz magnitude
        if (x == 0) begin
            pitch = 0;
        end else if (y == 0 && z == 0) begin
            pitch = (x > 0) ? -longint'(atpr_pkg::PITCH_LIM)
                            :  longint'(atpr_pkg::PITCH_LIM);
        end else begin
            ss    = y * y + z * z;
            r     = root_floor(ss << 32);
            pitch = centideg_of(vector_angle(r, -x * 65536, 0),
                                longint'(atpr_pkg::PITCH_LIM));
        end

        res.pitch_centideg = pitch[atpr_pkg::PITCH_W-1:0];
        res.roll_centideg  = roll[atpr_pkg::ROLL_W-1:0];
        return res;
    endfunction

    // idle after a word: runs with no gaps, otherwise mostly short and a few long
    function automatic int idle_pick(input int n);
        int r;
        r = $urandom_range(0, 99);
        if ((n / 150) % 3 == 2) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one axis value: full range, near zero, extreme or zero
    function automatic logic [15:0] axis_pick(input int kind);
        logic [15:0] v;
        case (kind)
            0: v = 16'($urandom);
            1: v = 16'($urandom_range(0, 16) - 8);
            2: begin
                case ($urandom_range(0, 5))
                    0:       v = 16'h8000;
                    1:       v = 16'h8001;
                    2:       v = 16'hFFFF;
                    3:       v = 16'h0001;
                    4:       v = 16'h7FFF;
                    default: v = 16'h0000;
                endcase
            end
            default: v = '0;
        endcase
        return v;
    endfunction

    task automatic add_word(input int x, input int y, input int z);
        t_word_slot slot;
        slot.sample.accel_x = x[15:0];
        slot.sample.accel_y = y[15:0];
        slot.sample.accel_z = z[15:0];
        slot.idle_after     = 8'(idle_pick(sample_q.size()));
        sample_q.push_back(slot);
    endtask

    // driver: words leave the queue, held until taken, idle counted from acceptance
    always @(posedge i_clk) begin
        if (i_start && o_busy === 1'b0) begin
            tilt_expected_q.push_back(tilt_of(i_sample));
            n_words_taken++;
        end
        if (i_start && o_busy !== 1'b0) begin
            i_start <= 1'b1;
        end else if (idle_left != 0) begin
            i_start   <= 1'b0;
            idle_left <= idle_left - 1;
        end else if (i_rst_n && sample_q.size() != 0) begin
            next_slot = sample_q.pop_front();
            i_start   <= 1'b1;
            i_sample  <= next_slot.sample;
            idle_left <= int'(next_slot.idle_after);
        end else begin
            i_start <= 1'b0;
        end
    end

    // monitor: every strobed tilt word against the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid !== 1'b0) begin
            if (tilt_expected_q.size() == 0) begin
                $error("tilt word with none expected: pitch %0d roll %0d",
                       $signed(o_result.pitch_centideg), $signed(o_result.roll_centideg));
                n_errors++;
            end else begin
                want = tilt_expected_q.pop_front();
                if (o_result.pitch_centideg !== want.pitch_centideg) begin
                    $error("pitch_centideg: expected %0d, got %0d",
                           $signed(want.pitch_centideg), $signed(o_result.pitch_centideg));
                    n_errors++;
                end
                if (o_result.roll_centideg !== want.roll_centideg) begin
                    $error("roll_centideg: expected %0d, got %0d",
                           $signed(want.roll_centideg), $signed(o_result.roll_centideg));
                    n_errors++;
                end
            end
        end
    end

    initial begin : stimulus
        int r;
        int kx;
        int ky;
        int kz;
        int drain;

        // zero vector, the z axis both ways, x alone both ways
        add_word(0, 0, 0);
        add_word(0, 0, 32767);
        add_word(0, 0, -32768);
        add_word(0, 0, -1);
        add_word(32767, 0, 0);
        add_word(-32768, 0, 0);
        add_word(1, 0, 0);
        // extremes of all fields
        add_word(32767, 32767, 32767);
        add_word(-32768, -32768, -32768);
        add_word(-32768, 32767, -32768);
        add_word(32767, -32768, 32767);
        add_word(-32768, -32768, 32767);
        // left half plane above and below, then one right half plane word
        add_word(100, 5000, -8000);
        add_word(-100, -5000, -8000);
        add_word(0, 1, -32768);
        add_word(0, -1, -32768);
        add_word(0, 1, 32767);
        // zero x with a tilted yz vector
        add_word(0, 1234, -4321);
        // near vertical pitch, z = 0 roll, then small equal-axis words
        add_word(32767, 1, 0);
        add_word(-32768, 0, 1);
        add_word(5, 32767, 0);
        add_word(-5, -32768, 0);
        add_word(1, 1, 1);
        add_word(-1, -1, -1);

        // random words: mostly full range, some mixed axis kinds, some near zero
        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                kx = 0;
                ky = 0;
                kz = 0;
            end else if (r < 85) begin
                kx = $urandom_range(0, 3);
                ky = $urandom_range(0, 3);
                kz = $urandom_range(0, 3);
            end else begin
                kx = 1;
                ky = 1;
                kz = 1;
            end
            add_word(int'($signed(axis_pick(kx))), int'($signed(axis_pick(ky))),
                     int'($signed(axis_pick(kz))));
        end
        n_words_total = sample_q.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_words_taken < n_words_total) @(posedge i_clk);
        drain = 0;
        while (tilt_expected_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (atpr_pkg::LATENCY + 8) @(posedge i_clk);
        if (tilt_expected_q.size() != 0) begin
            $error("%0d expected tilt words never arrived", tilt_expected_q.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog, several times the slowest correct run
    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
